// ===== hw/rtl/acms_pkg.sv =====
// Constants and register codes shared by the ADC channel moving-sum block.
`default_nettype none

package acms_pkg;

  localparam int CHANNELS_PER_BANK = 8;
  localparam int MAX_WINDOW        = 32;

  localparam int NUM_BANKS   = 2;
  localparam int NUM_GLOBAL  = 16;
  localparam int CH_W        = 4;
  localparam int DCH_W       = 3;
  localparam int SMP_W       = 10;
  localparam int SUM_W       = 15;
  localparam int WORD_W      = 32;
  localparam int DCH_LSB     = 24;
  localparam int SMP_LSB     = 6;
  localparam int WIN_FIELD_W = 6;
  localparam int MASK_W      = 16;
  localparam int WIN_REG_W   = 48;
  localparam int CFG_DATA_W  = 48;
  localparam int CFG_IDX_W   = 2;

  localparam int HEAD_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int RING_DEPTH = NUM_GLOBAL * MAX_WINDOW;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_TRACKED_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BANK0    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_BANK1    = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/acms_in_if.sv =====
// Input channel: raw converter result beats.
`default_nettype none

interface acms_in_if
  import acms_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              bank;
  logic [WORD_W-1:0] data_word;

  modport source (output valid, output bank, output data_word, input ready);
  modport sink   (input valid, input bank, input data_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/acms_out_if.sv =====
// Output channel: per-sample moving-sum result beats.
`default_nettype none

interface acms_out_if
  import acms_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [SMP_W-1:0] sample;
  logic [SUM_W-1:0] window_sum;
  logic             tracked;

  modport source (output valid, output channel, output sample, output window_sum,
                  output tracked, input ready);
  modport sink   (input valid, input channel, input sample, input window_sum,
                  input tracked, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adc_channel_moving_sum_unit.sv =====
// Top level: per-channel moving sum over converter results from two banks.
//
//  port     dir  role                  payload
//  src_i    in   converter result      bank, data_word
//  res_o    out  moving-sum result     channel, sample, window_sum, tracked
//  cfg_*_i  in   register writes       idx 0 mask, 1 bank0 windows, 2 bank1 windows
//
// One beat per cycle sustained while results are taken; a result passes through the
// second stage and the result register. Head pointer update and ring read happen at
// accept; the ring write, sum update and result register load happen as the second
// stage moves on, with same-slot forwarding. After reset the ring is cleared one slot
// per cycle, all RING_DEPTH (512) slots, with src_i.ready low. Config writes are taken
// at any time. A stalled result holds a full second stage, which drops src_i.ready.
`default_nettype none

module adc_channel_moving_sum_unit
  import acms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  acms_in_if.sink               src_i,
  acms_out_if.source            res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [MASK_W-1:0]    mask_q;
  logic [WIN_REG_W-1:0] win0_q, win1_q;

  logic [HEAD_W-1:0] head_q [NUM_GLOBAL];
  logic [SUM_W-1:0]  sum_q  [NUM_GLOBAL];

  logic               clr_busy_q;
  logic [RING_AW-1:0] clr_addr_q;

  logic               s1_vld_q, s1_trk_q;
  logic [CH_W-1:0]    s1_glb_q;
  logic [SMP_W-1:0]   s1_smp_q;
  logic [RING_AW-1:0] s1_addr_q;
  logic               byp_q;
  logic [SMP_W-1:0]   byp_smp_q;

  logic             out_vld_q, out_trk_q;
  logic [CH_W-1:0]  out_ch_q;
  logic [SMP_W-1:0] out_smp_q;
  logic [SUM_W-1:0] out_sum_q;

  logic [DCH_W-1:0]       in_dch;
  logic [SMP_W-1:0]       in_smp;
  logic [CH_W-1:0]        in_glb;
  logic                   in_trk;
  logic [WIN_REG_W-1:0]   win_sel;
  logic [WIN_FIELD_W-1:0] len_raw, len;
  logic [HEAD_W:0]        head_inc;
  logic [HEAD_W-1:0]      head_nxt;
  logic [RING_AW-1:0]     in_addr;
  logic                   accept, s1_move, s1_wr, byp_d;

  logic               mem_we;
  logic [RING_AW-1:0] mem_waddr;
  logic [SMP_W-1:0]   mem_wdata, mem_rdata, old_smp;
  logic [SUM_W-1:0]   new_sum;

  // decode and window lookup
  always_comb begin
    in_dch  = src_i.data_word[DCH_LSB +: DCH_W];
    in_smp  = src_i.data_word[SMP_LSB +: SMP_W];
    in_glb  = CH_W'(int'(src_i.bank) * CHANNELS_PER_BANK + int'(in_dch));
    in_trk  = (int'(in_dch) < CHANNELS_PER_BANK) && mask_q[in_glb];
    win_sel = src_i.bank ? win1_q : win0_q;
    len_raw = win_sel[in_dch * WIN_FIELD_W +: WIN_FIELD_W];
    if (len_raw == '0) begin
      len = WIN_FIELD_W'(1);
    end else if (int'(len_raw) > MAX_WINDOW) begin
      len = WIN_FIELD_W'(MAX_WINDOW);
    end else begin
      len = len_raw;
    end
    head_inc = {1'b0, head_q[in_glb]} + (HEAD_W+1)'(1);
    head_nxt = (int'(head_inc) >= int'(len)) ? '0 : head_inc[HEAD_W-1:0];
    in_addr  = RING_AW'(int'(in_glb) * MAX_WINDOW + int'(head_nxt));
  end

  assign s1_move     = s1_vld_q && (!out_vld_q || res_o.ready);
  assign src_i.ready = !clr_busy_q && (!s1_vld_q || s1_move);
  assign accept      = src_i.valid && src_i.ready;
  assign s1_wr       = s1_move && s1_trk_q;
  assign byp_d       = s1_wr && (s1_addr_q == in_addr);

  assign old_smp = byp_q ? byp_smp_q : mem_rdata;
  assign new_sum = sum_q[s1_glb_q] - SUM_W'(old_smp) + SUM_W'(s1_smp_q);

  assign mem_we    = clr_busy_q || s1_wr;
  assign mem_waddr = clr_busy_q ? clr_addr_q : s1_addr_q;
  assign mem_wdata = clr_busy_q ? '0 : s1_smp_q;

  acms_ring_mem u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (mem_rdata)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      win0_q <= '0;
      win1_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRACKED_MASK: mask_q <= cfg_data_i[MASK_W-1:0];
        REG_WIN_BANK0:    win0_q <= cfg_data_i[WIN_REG_W-1:0];
        REG_WIN_BANK1:    win1_q <= cfg_data_i[WIN_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ring clear after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + RING_AW'(1);
      if (clr_addr_q == RING_AW'(RING_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // per-channel heads and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GLOBAL; i++) begin
        head_q[i] <= '0;
        sum_q[i]  <= '0;
      end
    end else begin
      if (accept && in_trk) begin
        head_q[in_glb] <= head_nxt;
      end
      if (s1_wr) begin
        sum_q[s1_glb_q] <= new_sum;
      end
    end
  end

  // second stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (s1_move) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_glb_q  <= in_glb;
      s1_smp_q  <= in_smp;
      s1_trk_q  <= in_trk;
      s1_addr_q <= in_addr;
      byp_q     <= byp_d;
      byp_smp_q <= s1_smp_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_move) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_ch_q  <= s1_glb_q;
      out_smp_q <= s1_smp_q;
      out_trk_q <= s1_trk_q;
      out_sum_q <= s1_trk_q ? new_sum : '0;
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.channel    = out_ch_q;
  assign res_o.sample     = out_smp_q;
  assign res_o.window_sum = out_sum_q;
  assign res_o.tracked    = out_trk_q;

endmodule

`default_nettype wire

// ===== hw/rtl/acms_ring_mem.sv =====
// Sample ring storage for all channels, one write and one registered read port.
`default_nettype none

module acms_ring_mem
  import acms_pkg::*;
(
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [RING_AW-1:0] waddr_i,
  input  logic [SMP_W-1:0]   wdata_i,
  input  logic               re_i,
  input  logic [RING_AW-1:0] raddr_i,
  output logic [SMP_W-1:0]   rdata_o
);

  logic [SMP_W-1:0] mem_q [RING_DEPTH];
  logic [SMP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/acms_checker.sv =====
// Port-level checks for the moving-sum unit, bound to the top level.
`default_nettype none

module acms_checker
  import acms_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [SMP_W-1:0] out_sample_i,
  input logic [SUM_W-1:0] out_window_sum_i,
  input logic             out_tracked_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_window_sum_i))
    else $error("result beat dropped or changed while stalled");

  a_untracked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_tracked_i |-> out_window_sum_i == '0)
    else $error("untracked result carries a nonzero sum");

  a_sum_covers_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_tracked_i |-> int'(out_window_sum_i) >= int'(out_sample_i))
    else $error("window sum below its own newest sample");

  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i && !out_valid_i)
    else $error("input taken during ring clear");

endmodule

bind adc_channel_moving_sum_unit acms_checker u_acms_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (src_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .out_sample_i     (res_o.sample),
  .out_window_sum_i (res_o.window_sum),
  .out_tracked_i    (res_o.tracked)
);

`default_nettype wire

// ===== tb/sv/acms_moving_sum_checker.sv =====
// Checker for the ADC channel moving-sum unit: tracks rings and sums, compares result beats.
`timescale 1ns / 1ps

module acms_moving_sum_checker
  import acms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  in_bank_i,
  input  logic [WORD_W-1:0]     in_word_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [CH_W-1:0]       out_channel_i,
  input  logic [SMP_W-1:0]      out_sample_i,
  input  logic [SUM_W-1:0]      out_window_sum_i,
  input  logic                  out_tracked_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    results_o,
  output int                    tracked_o
);

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] sample;
    logic [SUM_W-1:0] window_sum;
    logic             tracked;
  } moving_sum_t;

  moving_sum_t      expected_sums_q[$];
  logic [SMP_W-1:0] ring_mem [NUM_GLOBAL][MAX_WINDOW];
  logic [HEAD_W-1:0] head_ptr [NUM_GLOBAL];
  logic [SUM_W-1:0] chan_sum [NUM_GLOBAL];
  logic [MASK_W-1:0] track_mask;
  logic [WIN_REG_W-1:0] win_bank [NUM_BANKS];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict_and_check
    int               g;
    int               len;
    int               nxt;
    logic [DCH_W-1:0] dch;
    moving_sum_t      want;
    moving_sum_t      next_sum;
    if (!rst_ni) begin
      for (int c = 0; c < NUM_GLOBAL; c++) begin
        for (int s = 0; s < MAX_WINDOW; s++) ring_mem[c][s] = '0;
        head_ptr[c] = '0;
        chan_sum[c] = '0;
      end
      track_mask = '0;
      win_bank[0] = '0;
      win_bank[1] = '0;
      expected_sums_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      results_o = 0;
      tracked_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TRACKED_MASK: track_mask = cfg_data_i[MASK_W-1:0];
          REG_WIN_BANK0:    win_bank[0] = cfg_data_i[WIN_REG_W-1:0];
          REG_WIN_BANK1:    win_bank[1] = cfg_data_i[WIN_REG_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_sums_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat: channel %0d sample %0d",
                                    out_channel_i, out_sample_i));
        end else begin
          want = expected_sums_q.pop_front();
          if (out_channel_i !== want.channel)
            report_mismatch($sformatf("channel %0d, expected %0d",
                                      out_channel_i, want.channel));
          if (out_sample_i !== want.sample)
            report_mismatch($sformatf("ch %0d sample %0d, expected %0d",
                                      want.channel, out_sample_i, want.sample));
          if (out_window_sum_i !== want.window_sum)
            report_mismatch($sformatf("ch %0d window_sum %0d, expected %0d",
                                      want.channel, out_window_sum_i, want.window_sum));
          if (out_tracked_i !== want.tracked)
            report_mismatch($sformatf("ch %0d tracked %0b, expected %0b",
                                      want.channel, out_tracked_i, want.tracked));
          results_o++;
          if (want.tracked) tracked_o++;
        end
      end

      if (in_valid_i && in_ready_i) begin
        dch = in_word_i[DCH_LSB +: DCH_W];
        g = (int'(in_bank_i) * CHANNELS_PER_BANK + int'(dch)) % NUM_GLOBAL;
        next_sum.channel = g[CH_W-1:0];
        next_sum.sample = in_word_i[SMP_LSB +: SMP_W];
        next_sum.window_sum = '0;
        next_sum.tracked = (int'(dch) < CHANNELS_PER_BANK) && track_mask[g];
        if (next_sum.tracked) begin
          len = int'(win_bank[in_bank_i][int'(dch) * WIN_FIELD_W +: WIN_FIELD_W]);
          if (len == 0) len = 1;
          if (len > MAX_WINDOW) len = MAX_WINDOW;
          nxt = int'(head_ptr[g]) + 1;
          if (nxt >= len) nxt = 0;
          chan_sum[g] = chan_sum[g] - ring_mem[g][nxt] + next_sum.sample;
          ring_mem[g][nxt] = next_sum.sample;
          head_ptr[g] = nxt[HEAD_W-1:0];
          next_sum.window_sum = chan_sum[g];
        end
        expected_sums_q.push_back(next_sum);
      end

      pending_o = expected_sums_q.size();
    end
  end

endmodule

// ===== tb/sv/adc_channel_moving_sum_unit_tb.sv =====
// Testbench top for the ADC channel moving-sum unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module adc_channel_moving_sum_unit_tb;
  import acms_pkg::*;

  localparam int                CYCLE_LIMIT = 100000;
  localparam logic [WORD_W-1:0] FIELD_BITS  = 32'h0700_FFC0;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int src_idle_pct = 0;
  int rcv_idle_pct = 0;
  int cycles = 0;
  int fail_count;
  int pending;
  int results;
  int tracked_results;

  acms_in_if  src_if ();
  acms_out_if res_if ();

  adc_channel_moving_sum_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .src_i      (src_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  acms_moving_sum_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (src_if.valid),
    .in_ready_i       (src_if.ready),
    .in_bank_i        (src_if.bank),
    .in_word_i        (src_if.data_word),
    .out_valid_i      (res_if.valid),
    .out_ready_i      (res_if.ready),
    .out_channel_i    (res_if.channel),
    .out_sample_i     (res_if.sample),
    .out_window_sum_i (res_if.window_sum),
    .out_tracked_i    (res_if.tracked),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .results_o        (results),
    .tracked_o        (tracked_results)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [WORD_W-1:0] compose_word(input logic [DCH_W-1:0] ch,
                                                     input logic [SMP_W-1:0] smp,
                                                     input logic [WORD_W-1:0] noise);
    logic [WORD_W-1:0] w;
    w = noise & ~FIELD_BITS;
    w[DCH_LSB +: DCH_W] = ch;
    w[SMP_LSB +: SMP_W] = smp;
    return w;
  endfunction

  task automatic write_registers(input logic [MASK_W-1:0] mask,
                                 input logic [WIN_REG_W-1:0] win0,
                                 input logic [WIN_REG_W-1:0] win1);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_TRACKED_MASK;
    cfg_data <= CFG_DATA_W'(mask);
    @(posedge clk_i);
    cfg_idx  <= REG_WIN_BANK0;
    cfg_data <= CFG_DATA_W'(win0);
    @(posedge clk_i);
    cfg_idx  <= REG_WIN_BANK1;
    cfg_data <= CFG_DATA_W'(win1);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_beat(input logic bank, input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < src_idle_pct) begin
      src_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    src_if.valid     <= 1'b1;
    src_if.bank      <= bank;
    src_if.data_word <= word;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
  endtask

  task automatic send_random(input logic focus_bank, input logic [DCH_W-1:0] focus_ch);
    logic             b;
    logic [DCH_W-1:0] c;
    logic [SMP_W-1:0] s;
    case ($urandom_range(7))
      0:       s = '0;
      1:       s = '1;
      default: s = SMP_W'($urandom_range(1023));
    endcase
    if ($urandom_range(9) < 6) begin
      b = focus_bank;
      c = focus_ch;
    end else begin
      b = 1'($urandom_range(1));
      c = DCH_W'($urandom_range(7));
    end
    send_beat(b, compose_word(c, s, $urandom()));
  endtask

  // Hold the sender until the result queue is empty, then let the pipe settle.
  task automatic drain();
    src_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_items, input int send_pct, input int recv_pct,
                           input logic [MASK_W-1:0] mask,
                           input logic [WIN_REG_W-1:0] win0,
                           input logic [WIN_REG_W-1:0] win1);
    logic             fb;
    logic [DCH_W-1:0] fc;
    src_idle_pct = send_pct;
    rcv_idle_pct = recv_pct;
    write_registers(mask, win0, win1);
    fb = 1'($urandom_range(1));
    fc = DCH_W'($urandom_range(7));
    for (int i = 0; i < n_items; i++) send_random(fb, fc);
    drain();
  endtask

  initial begin
    logic [2*WIN_REG_W-1:0] short_win;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = REG_TRACKED_MASK;
    cfg_data         = '0;
    src_if.valid     = 1'b0;
    src_if.bank      = 1'b0;
    src_if.data_word = '0;
    res_if.ready     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // bank 0 windows ch7..ch0: 33, 3, 2, 1, 32, 63, 0, 0; global 0 and 15 untracked
    src_idle_pct = 7;
    rcv_idle_pct = 59;
    write_registers(16'h7FFE,
                    {6'd33, 6'd3, 6'd2, 6'd1, 6'd32, 6'd63, 6'd0, 6'd0},
                    {6'd7, 6'd31, 6'd30, 6'd5, 6'd1, 6'd4, 6'd0, 6'd3});
    send_beat(1'b0, compose_word(3'd1, 10'd1023, '1));
    send_beat(1'b0, compose_word(3'd1, 10'd5, '0));
    send_beat(1'b0, compose_word(3'd1, 10'd1023, '1));
    send_beat(1'b0, compose_word(3'd0, 10'd1023, '1));
    send_beat(1'b1, compose_word(3'd7, 10'd0, '0));
    send_beat(1'b0, compose_word(3'd2, 10'd1023, '1));
    send_beat(1'b0, compose_word(3'd2, 10'd1023, '0));
    send_beat(1'b0, compose_word(3'd2, 10'd1023, '1));
    send_beat(1'b0, compose_word(3'd4, 10'd1023, '0));
    send_beat(1'b0, compose_word(3'd4, 10'd0, '1));
    send_beat(1'b0, compose_word(3'd5, 10'd1023, '0));
    send_beat(1'b0, compose_word(3'd5, 10'd1023, '1));
    send_beat(1'b0, compose_word(3'd5, 10'd1023, '0));
    send_beat(1'b1, compose_word(3'd0, 10'd0, '1));
    send_beat(1'b1, compose_word(3'd0, 10'd1023, '0));
    send_beat(1'b1, compose_word(3'd0, 10'd512, '1));
    send_beat(1'b1, compose_word(3'd0, 10'd1, '0));
    send_beat(1'b0, compose_word(3'd7, 10'd1023, '1));
    send_beat(1'b1, compose_word(3'd3, 10'd1023, '0));
    drain();

    run_phase(130, 7, 59, '1, '1, '1);
    run_phase(120, 59, 7, MASK_W'($urandom_range(65535)),
              WIN_REG_W'({$urandom(), $urandom()}), WIN_REG_W'({$urandom(), $urandom()}));
    run_phase(30, 0, 0, '0, '0, '0);
    // short windows shrink below heads left by the earlier settings
    for (int i = 0; i < 2 * NUM_GLOBAL / 2; i++) begin
      short_win[i * WIN_FIELD_W +: WIN_FIELD_W] = WIN_FIELD_W'($urandom_range(4));
    end
    for (int i = NUM_GLOBAL / 2; i < NUM_GLOBAL; i++) begin
      short_win[i * WIN_FIELD_W +: WIN_FIELD_W] = WIN_FIELD_W'($urandom_range(4));
    end
    run_phase(120, 0, 0, MASK_W'($urandom_range(65535)) | 16'h0101,
              short_win[WIN_REG_W-1:0], short_win[2*WIN_REG_W-1:WIN_REG_W]);

    $display("Checked %0d result beats (%0d on tracked channels): directed edge cases,",
             results, tracked_results);
    $display("full, random, cleared and shortened windows under both stall mixes and none.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
